@@ src/greedy_grid_edge_placer_macros.svh @@
// Assertion macros for the greedy grid edge placer checker
`ifndef GREEDY_GRID_EDGE_PLACER_MACROS_SVH
`define GREEDY_GRID_EDGE_PLACER_MACROS_SVH

// same-cycle implication under reset
`define GGEP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ggep assertion failed");

// next-cycle implication under reset
`define GGEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ggep assertion failed");

`endif

@@ src/ggep_pkg.sv @@
// Shared types, constants and offset table for the greedy grid edge placer
`default_nettype none
package ggep_pkg;

    localparam int POS_W          = 4;
    localparam int COST_W         = 20;
    localparam int NODE_IN_W      = 7;
    localparam int TABLE_LEN      = 28;
    localparam int OFF_W          = 5;
    localparam int STEP_W         = 4;
    localparam int GRID_SIDE_DEF  = 9;
    localparam int NODE_COUNT_DEF = 128;
    localparam int OFFSET_COUNT_DEF = 28;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef struct packed {
        logic [NODE_IN_W-1:0] src_node;
        logic [NODE_IN_W-1:0] dst_node;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  src_x;
        logic [POS_W-1:0]  src_y;
        logic [POS_W-1:0]  dst_x;
        logic [POS_W-1:0]  dst_y;
        logic [COST_W-1:0] wire_cost;
        logic [COST_W-1:0] hop_cost;
        logic              failed;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } node_pos_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } probe_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDP,
        S_RDS,
        S_SRC,
        S_SRCH,
        S_RDD,
        S_DST,
        S_COST,
        S_DONE
    } state_t;

    function automatic logic signed [STEP_W-1:0] step_row(input logic [OFF_W-1:0] k);
        logic signed [STEP_W-1:0] v;
        case (k)
            5'd0:  v = 4'sd0;   5'd1:  v = 4'sd1;   5'd2:  v = 4'sd0;   5'd3:  v = -4'sd1;
            5'd4:  v = -4'sd1;  5'd5:  v = 4'sd1;   5'd6:  v = 4'sd1;   5'd7:  v = -4'sd1;
            5'd8:  v = 4'sd0;   5'd9:  v = 4'sd2;   5'd10: v = 4'sd0;   5'd11: v = -4'sd2;
            5'd12: v = -4'sd1;  5'd13: v = 4'sd1;   5'd14: v = 4'sd1;   5'd15: v = -4'sd1;
            5'd16: v = -4'sd2;  5'd17: v = 4'sd2;   5'd18: v = 4'sd2;   5'd19: v = -4'sd2;
            5'd20: v = 4'sd0;   5'd21: v = 4'sd4;   5'd22: v = 4'sd0;   5'd23: v = -4'sd4;
            5'd24: v = 4'sd1;   5'd25: v = 4'sd1;   5'd26: v = -4'sd1;  5'd27: v = -4'sd1;
            default: v = 4'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [STEP_W-1:0] step_col(input logic [OFF_W-1:0] k);
        logic signed [STEP_W-1:0] v;
        case (k)
            5'd0:  v = 4'sd1;   5'd1:  v = 4'sd0;   5'd2:  v = -4'sd1;  5'd3:  v = 4'sd0;
            5'd4:  v = 4'sd1;   5'd5:  v = 4'sd1;   5'd6:  v = -4'sd1;  5'd7:  v = -4'sd1;
            5'd8:  v = 4'sd2;   5'd9:  v = 4'sd0;   5'd10: v = -4'sd2;  5'd11: v = 4'sd0;
            5'd12: v = 4'sd2;   5'd13: v = 4'sd2;   5'd14: v = -4'sd2;  5'd15: v = -4'sd2;
            5'd16: v = 4'sd1;   5'd17: v = 4'sd1;   5'd18: v = -4'sd1;  5'd19: v = -4'sd1;
            5'd20: v = 4'sd4;   5'd21: v = 4'sd0;   5'd22: v = -4'sd4;  5'd23: v = 4'sd0;
            5'd24: v = 4'sd3;   5'd25: v = -4'sd3;  5'd26: v = -4'sd3;  5'd27: v = 4'sd3;
            default: v = 4'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/ggep_probe.sv @@
// Offset probe: bounds check and registered occupancy read, one candidate cell per cycle
`default_nettype none
module ggep_probe #(
    parameter int GRID_SIDE = ggep_pkg::GRID_SIDE_DEF,
    parameter int CELL_N    = GRID_SIDE * GRID_SIDE,
    parameter int CELL_W    = $clog2(CELL_N)
) (
    input  wire logic                       clk,
    input  wire logic [ggep_pkg::POS_W-1:0] base_row,
    input  wire logic [ggep_pkg::POS_W-1:0] base_col,
    input  wire logic [ggep_pkg::OFF_W-1:0] k,
    input  wire logic [CELL_N-1:0]          cells,
    output ggep_pkg::probe_res_t            res,
    output logic [CELL_W-1:0]               addr
);
    import ggep_pkg::*;

    logic signed [POS_W+1:0] r_s;
    logic signed [POS_W+1:0] c_s;
    logic                    in_bounds;
    logic [CELL_W-1:0]       addr_c;
    logic                    blocked_reg;
    logic [POS_W-1:0]        row_reg;
    logic [POS_W-1:0]        col_reg;
    logic [CELL_W-1:0]       addr_reg;

    always_comb
    begin
        r_s = $signed({2'b00, base_row}) + (POS_W+2)'(step_row(k));
        c_s = $signed({2'b00, base_col}) + (POS_W+2)'(step_col(k));
        in_bounds = (r_s >= 0) && (r_s < GRID_SIDE) && (c_s >= 0) && (c_s < GRID_SIDE);
        addr_c = CELL_W'(int'(r_s[POS_W-1:0]) * GRID_SIDE + int'(c_s[POS_W-1:0]));
    end

    // result is registered: it shows the candidate presented in the cycle before
    always_ff @(posedge clk)
    begin
        blocked_reg <= in_bounds ? cells[addr_c] : 1'b1;
        row_reg     <= r_s[POS_W-1:0];
        col_reg     <= c_s[POS_W-1:0];
        addr_reg    <= addr_c;
    end

    always_comb
    begin
        res.hit = !blocked_reg;
        res.row = row_reg;
        res.col = col_reg;
        addr    = addr_reg;
    end

endmodule
`default_nettype wire

@@ src/ggep_node_mem.sv @@
// Node position store: one write port, one registered read port, valid flops
`default_nettype none
module ggep_node_mem #(
    parameter int NODE_COUNT = ggep_pkg::NODE_COUNT_DEF,
    parameter int NODE_W     = $clog2(NODE_COUNT)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [NODE_W-1:0]   wr_addr,
    input  ggep_pkg::node_pos_t      wr_pos,
    input  wire logic [NODE_W-1:0]   rd_addr,
    output ggep_pkg::node_pos_t      rd_pos
);
    import ggep_pkg::*;

    logic [2*POS_W-1:0]    mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] valid_reg;
    logic [2*POS_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_pos.row, wr_pos.col};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // unplaced nodes read as (0,0)
    always_comb
    begin
        rd_pos.valid = rd_valid_reg;
        rd_pos.row   = rd_valid_reg ? rd_data_reg[2*POS_W-1:POS_W] : '0;
        rd_pos.col   = rd_valid_reg ? rd_data_reg[POS_W-1:0] : '0;
    end

endmodule
`default_nettype wire

@@ src/greedy_grid_edge_placer.sv @@
// Greedy grid edge placer: top level with sequencer, occupancy grid and cost totals
// Each transaction on the item channel is one graph edge; one result transaction follows it.
// An edge whose nodes are both already placed passes through S_RDP, S_RDS, S_SRC, S_RDD,
// S_DST, S_COST and S_DONE to the result register, and the next edge is accepted once the
// sequencer is back in S_IDLE. Each unplaced node but the first source after reset, which
// goes to cell (0,0), is searched by priming the registered occupancy read and then probing
// the offsets in turn, because the single probe unit checks one candidate cell per cycle;
// the node position store has one read port, so the previous source, source and destination
// positions are read in turn. After a placement failure each edge goes from S_IDLE straight
// to S_DONE and reports zero positions. The item channel stalls while an edge is in work; a
// finished result waits in the output register while the next edge runs, and an edge that
// finishes while that register still holds an unaccepted result waits for it.
`default_nettype none
module greedy_grid_edge_placer #(
    parameter int GRID_SIDE    = ggep_pkg::GRID_SIDE_DEF,
    parameter int NODE_COUNT   = ggep_pkg::NODE_COUNT_DEF,
    parameter int OFFSET_COUNT = ggep_pkg::OFFSET_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  ggep_pkg::item_t    item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output ggep_pkg::result_t  result
);
    import ggep_pkg::*;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CELL_N = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W = $clog2(CELL_N);
    localparam int IN_MAX = (1 << NODE_IN_W) - 1;

    function automatic logic [NODE_W-1:0] node_index(input logic [NODE_IN_W-1:0] v);
        logic [NODE_IN_W-1:0] r;
        r = v;
        for (int k = NODE_IN_W - 1; k >= 0; k--)
        begin
            if ((NODE_COUNT << k) <= IN_MAX)
            begin
                if (int'(r) >= (NODE_COUNT << k))
                begin
                    r = r - NODE_IN_W'(NODE_COUNT << k);
                end
            end
        end
        return NODE_W'(r);
    endfunction

    state_t              state_reg, state_next;
    logic [NODE_W-1:0]   s_reg, s_next;
    logic [NODE_W-1:0]   d_reg, d_next;
    logic [NODE_W-1:0]   prev_reg, prev_next;
    logic                any_reg, any_next;
    logic                fail_reg, fail_next;
    logic [COST_W-1:0]   wire_reg, wire_next;
    logic [COST_W-1:0]   hop_reg, hop_next;
    logic [POS_W-1:0]    base_row_reg, base_row_next;
    logic [POS_W-1:0]    base_col_reg, base_col_next;
    logic [POS_W-1:0]    sr_reg, sr_next;
    logic [POS_W-1:0]    sc_reg, sc_next;
    logic [POS_W-1:0]    dr_reg, dr_next;
    logic [POS_W-1:0]    dc_reg, dc_next;
    logic [OFF_W-1:0]    k_reg, k_next;
    logic                tgt_dst_reg, tgt_dst_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic [CELL_N-1:0]   cells_reg, cells_next;

    probe_res_t          pr;
    logic [CELL_W-1:0]   pr_addr;
    logic                wr_en;
    logic [NODE_W-1:0]   wr_addr;
    node_pos_t           wr_pos;
    logic [NODE_W-1:0]   rd_addr;
    node_pos_t           rd_pos;

    logic [POS_W-1:0]    adx, ady;
    logic [POS_W:0]      wsum;
    logic [POS_W-1:0]    hsum;
    logic [COST_W:0]     wire_add, hop_add;
    logic                accept;

    ggep_probe #(
        .GRID_SIDE (GRID_SIDE),
        .CELL_N    (CELL_N),
        .CELL_W    (CELL_W)
    ) u_probe (
        .clk      (clk),
        .base_row (base_row_reg),
        .base_col (base_col_reg),
        .k        (k_reg),
        .cells    (cells_reg),
        .res      (pr),
        .addr     (pr_addr)
    );

    ggep_node_mem #(
        .NODE_COUNT (NODE_COUNT),
        .NODE_W     (NODE_W)
    ) u_node_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_pos  (wr_pos),
        .rd_addr (rd_addr),
        .rd_pos  (rd_pos)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        adx      = (sr_reg > dr_reg) ? (sr_reg - dr_reg) : (dr_reg - sr_reg);
        ady      = (sc_reg > dc_reg) ? (sc_reg - dc_reg) : (dc_reg - sc_reg);
        wsum     = {1'b0, adx} + {1'b0, ady};
        hsum     = POS_W'(({1'b0, adx} + 1'b1) >> 1) + POS_W'(({1'b0, ady} + 1'b1) >> 1);
        wire_add = {1'b0, wire_reg} + (COST_W+1)'(wsum - 1'b1);
        hop_add  = {1'b0, hop_reg} + (COST_W+1)'(hsum - 1'b1);
    end

    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        d_next         = d_reg;
        prev_next      = prev_reg;
        any_next       = any_reg;
        fail_next      = fail_reg;
        wire_next      = wire_reg;
        hop_next       = hop_reg;
        base_row_next  = base_row_reg;
        base_col_next  = base_col_reg;
        sr_next        = sr_reg;
        sc_next        = sc_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        k_next         = k_reg;
        tgt_dst_next   = tgt_dst_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cells_next     = cells_reg;
        wr_en          = 1'b0;
        wr_addr        = s_reg;
        wr_pos         = '0;
        rd_addr        = prev_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    s_next = node_index(item.src_node);
                    d_next = node_index(item.dst_node);
                    if (fail_reg)
                    begin
                        sr_next    = '0;
                        sc_next    = '0;
                        dr_next    = '0;
                        dc_next    = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RDP;
                    end
                end
            end
            S_RDP:
            begin
                rd_addr    = prev_reg;
                state_next = S_RDS;
            end
            S_RDS:
            begin
                rd_addr       = s_reg;
                base_row_next = rd_pos.row;
                base_col_next = rd_pos.col;
                state_next    = S_SRC;
            end
            S_SRC:
            begin
                if (!any_reg)
                begin
                    any_next = 1'b1;
                    sr_next  = rd_pos.row;
                    sc_next  = rd_pos.col;
                    if (!rd_pos.valid)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = s_reg;
                        wr_pos        = '0;
                        cells_next[0] = 1'b1;
                    end
                    state_next = S_RDD;
                end
                else if (rd_pos.valid)
                begin
                    sr_next    = rd_pos.row;
                    sc_next    = rd_pos.col;
                    state_next = S_RDD;
                end
                else
                begin
                    k_next       = '0;
                    tgt_dst_next = 1'b0;
                    state_next   = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // probe result is registered and belongs to the previous k; k of zero only primes the read
                k_next = k_reg + 1'b1;
                if ((k_reg != '0) && pr.hit)
                begin
                    wr_en               = 1'b1;
                    wr_addr             = tgt_dst_reg ? d_reg : s_reg;
                    wr_pos.valid        = 1'b1;
                    wr_pos.row          = pr.row;
                    wr_pos.col          = pr.col;
                    cells_next[pr_addr] = 1'b1;
                    if (tgt_dst_reg)
                    begin
                        dr_next    = pr.row;
                        dc_next    = pr.col;
                        state_next = S_COST;
                    end
                    else
                    begin
                        sr_next    = pr.row;
                        sc_next    = pr.col;
                        state_next = S_RDD;
                    end
                end
                else if (k_reg == OFF_W'(OFFSET_COUNT))
                begin
                    fail_next  = 1'b1;
                    sr_next    = '0;
                    sc_next    = '0;
                    dr_next    = '0;
                    dc_next    = '0;
                    state_next = S_DONE;
                end
            end
            S_RDD:
            begin
                rd_addr    = d_reg;
                prev_next  = s_reg;
                state_next = S_DST;
            end
            S_DST:
            begin
                if (rd_pos.valid)
                begin
                    dr_next    = rd_pos.row;
                    dc_next    = rd_pos.col;
                    state_next = S_COST;
                end
                else
                begin
                    base_row_next = sr_reg;
                    base_col_next = sc_reg;
                    k_next        = '0;
                    tgt_dst_next  = 1'b1;
                    state_next    = S_SRCH;
                end
            end
            S_COST:
            begin
                if (wsum == '0)
                begin
                    wire_next = (wire_reg == '0) ? '0 : wire_reg - 1'b1;
                end
                else
                begin
                    wire_next = wire_add[COST_W] ? COST_MAX : wire_add[COST_W-1:0];
                end
                if (hsum == '0)
                begin
                    hop_next = (hop_reg == '0) ? '0 : hop_reg - 1'b1;
                end
                else
                begin
                    hop_next = hop_add[COST_W] ? COST_MAX : hop_add[COST_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next     = 1'b1;
                    out_next.src_x     = sr_reg;
                    out_next.src_y     = sc_reg;
                    out_next.dst_x     = dr_reg;
                    out_next.dst_y     = dc_reg;
                    out_next.wire_cost = wire_reg;
                    out_next.hop_cost  = hop_reg;
                    out_next.failed    = fail_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            any_reg       <= 1'b0;
            fail_reg      <= 1'b0;
            wire_reg      <= '0;
            hop_reg       <= '0;
            out_valid_reg <= 1'b0;
            cells_reg     <= '0;
            k_reg         <= '0;
            tgt_dst_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            any_reg       <= any_next;
            fail_reg      <= fail_next;
            wire_reg      <= wire_next;
            hop_reg       <= hop_next;
            out_valid_reg <= out_valid_next;
            cells_reg     <= cells_next;
            k_reg         <= k_next;
            tgt_dst_reg   <= tgt_dst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        d_reg        <= d_next;
        base_row_reg <= base_row_next;
        base_col_reg <= base_col_next;
        sr_reg       <= sr_next;
        sc_reg       <= sc_next;
        dr_reg       <= dr_next;
        dc_reg       <= dc_next;
        out_reg      <= out_next;
    end

endmodule
`default_nettype wire

@@ src/ggep_checker.sv @@
// Port-level checker for the greedy grid edge placer, bound to the top level
`default_nettype none
`include "greedy_grid_edge_placer_macros.svh"
module ggep_checker #(
    parameter int GRID_SIDE = ggep_pkg::GRID_SIDE_DEF
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          item_valid,
    input wire logic          item_stall,
    input wire logic          result_valid,
    input wire logic          result_stall,
    input ggep_pkg::result_t  result
);
    import ggep_pkg::*;

    logic fail_shown;
    logic pos_in_grid;
    logic pos_zero;

    assign fail_shown  = result_valid && result.failed;
    assign pos_in_grid = (result.src_x < GRID_SIDE) && (result.src_y < GRID_SIDE)
                         && (result.dst_x < GRID_SIDE) && (result.dst_y < GRID_SIDE);
    assign pos_zero    = (result.src_x == '0) && (result.src_y == '0)
                         && (result.dst_x == '0) && (result.dst_y == '0);

    `GGEP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))
    `GGEP_ASSERT_NEXT(a_fail_sticky, clk, rst_n, fail_shown, !result_valid || result.failed)
    `GGEP_ASSERT_NOW(a_fail_no_pos, clk, rst_n, fail_shown, pos_zero)
    `GGEP_ASSERT_NOW(a_pos_in_grid, clk, rst_n, result_valid, pos_in_grid)
    `GGEP_ASSERT_NEXT(a_item_busy, clk, rst_n, item_valid && !item_stall, item_stall)

endmodule

bind greedy_grid_edge_placer ggep_checker #(.GRID_SIDE(GRID_SIDE)) u_ggep_checker (.*);
`default_nettype wire
